>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds in the same cycle, outside of reset.
`define CHECK_SAME(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// Checks that an implication holds in the cycle that follows, outside of reset.
`define CHECK_NEXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

>>> hw/rtl/ihex_pkg.sv
package ihex_pkg;

  // Field widths of the character and result words.
  localparam int unsigned CharW   = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned FillW   = 16;
  localparam int unsigned ErrW    = 3;
  localparam int unsigned OutAddrW = 17;

  // Result kinds.
  localparam logic [KindW-1:0] RK_DATA  = 2'd0;
  localparam logic [KindW-1:0] RK_FILL  = 2'd1;
  localparam logic [KindW-1:0] RK_DONE  = 2'd2;
  localparam logic [KindW-1:0] RK_ERROR = 2'd3;

  // Error codes.
  localparam logic [ErrW-1:0] ERR_DIGIT = 3'd0;
  localparam logic [ErrW-1:0] ERR_EARLY = 3'd1;
  localparam logic [ErrW-1:0] ERR_SEQ   = 3'd2;
  localparam logic [ErrW-1:0] ERR_TYPE  = 3'd3;
  localparam logic [ErrW-1:0] ERR_SUM   = 3'd4;

  // Input word kinds.
  localparam logic KIND_CHAR = 1'b0;

  // Record types.
  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;

  // ASCII codes used by the decoder.
  localparam logic [CharW-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CharW-1:0] CHAR_0     = 8'h30;
  localparam logic [CharW-1:0] CHAR_9     = 8'h39;
  localparam logic [CharW-1:0] CHAR_A     = 8'h41;
  localparam logic [CharW-1:0] CHAR_F     = 8'h46;

  // Value of the letter digit A.
  localparam logic [3:0] NIB_TEN = 4'd10;

  // Record decoding phases, one-hot.
  typedef enum logic [8:0] {
    PH_HUNT  = 9'b000000001,
    PH_COUNT = 9'b000000010,
    PH_AHI   = 9'b000000100,
    PH_ALO   = 9'b000001000,
    PH_TYPE  = 9'b000010000,
    PH_DATA  = 9'b000100000,
    PH_CHECK = 9'b001000000,
    PH_DONE  = 9'b010000000,
    PH_ERROR = 9'b100000000
  } phase_t;

endpackage

>>> hw/rtl/ihex_in_if.sv
interface ihex_in_if;
  import ihex_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [CharW-1:0] char_code;

  modport source (output valid, output kind, output char_code, input ready);
  modport sink   (input valid, input kind, input char_code, output ready);
endinterface

>>> hw/rtl/ihex_out_if.sv
interface ihex_out_if;
  import ihex_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] result_kind;
  logic [7:0]       data_byte;
  logic [FillW-1:0] fill_length;
  logic [ErrW-1:0]  error_code;

  modport source (output valid, output result_kind, output data_byte,
                  output fill_length, output error_code, input ready);
  modport sink   (input valid, input result_kind, input data_byte,
                  input fill_length, input error_code, output ready);
endinterface

>>> hw/rtl/intel_hex_record_parser.sv
// Intel HEX record parser: takes one ASCII character word per cycle, unless a
// result waits in the output register and the output stalls, and turns the
// text into a binary image stream of data bytes and zero-fill runs, ending
// with a done word, or stops with an error word (bad digit, early end, record
// out of order, unknown type, checksum). The record decoder state updates in
// the accepting cycle and the one result it may cause lands in the output
// register, which frees again in the cycle it is taken. After a done or error
// word the block swallows all input without results until reset.
module intel_hex_record_parser (
  input  logic       clk,
  input  logic       rst_n,
  ihex_in_if.sink    in_chan,
  ihex_out_if.source out_chan
);
  import ihex_pkg::*;

  `include "assert_macros.svh"

  // Decoder state.
  phase_t                phase_r, phase_nxt;
  logic                  second_nibble_r, second_nibble_nxt;
  logic [3:0]            high_nibble_r, high_nibble_nxt;
  logic [7:0]            running_sum_r, running_sum_nxt;
  logic [7:0]            record_length_r, record_length_nxt;
  logic [7:0]            bytes_left_r, bytes_left_nxt;
  logic [7:0]            address_high_r, address_high_nxt;
  logic [15:0]           record_address_r, record_address_nxt;
  logic                  end_record_r, end_record_nxt;
  logic [OutAddrW-1:0]   output_address_r, output_address_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [KindW-1:0]      out_kind_r, out_kind_nxt;
  logic [7:0]            out_byte_r, out_byte_nxt;
  logic [FillW-1:0]      out_fill_r, out_fill_nxt;
  logic [ErrW-1:0]       out_err_r, out_err_nxt;

  logic                  in_accept;
  logic                  halted;
  logic                  res_valid;
  logic [KindW-1:0]      res_kind;
  logic [7:0]            res_byte;
  logic [FillW-1:0]      res_fill;
  logic [ErrW-1:0]       res_err;
  logic                  nib_ok;
  logic [3:0]            nib_val;
  logic [7:0]            byte_val;
  logic [7:0]            sum_new;
  logic [7:0]            left_dec;
  logic [OutAddrW-1:0]   rec_addr_ext;

  // A new word is taken whenever the output register is empty or draining.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_accept     = in_chan.valid && in_chan.ready;
  assign halted        = (phase_r == PH_DONE) || (phase_r == PH_ERROR);

  // Uppercase hex digit decode.
  always_comb begin
    nib_ok  = 1'b1;
    nib_val = '0;
    case (in_chan.char_code) inside
      [CHAR_0:CHAR_9]: nib_val = 4'(in_chan.char_code - CHAR_0);
      [CHAR_A:CHAR_F]: nib_val = 4'(in_chan.char_code - CHAR_A) + NIB_TEN;
      default:         nib_ok  = 1'b0;
    endcase
  end

  assign byte_val     = {high_nibble_r, nib_val};
  assign sum_new      = running_sum_r + byte_val;
  assign left_dec     = bytes_left_r - 8'd1;
  assign rec_addr_ext = {1'b0, record_address_r};

  // Record decoder: next state and the result of the current word.
  always_comb begin
    phase_nxt          = phase_r;
    second_nibble_nxt  = second_nibble_r;
    high_nibble_nxt    = high_nibble_r;
    running_sum_nxt    = running_sum_r;
    record_length_nxt  = record_length_r;
    bytes_left_nxt     = bytes_left_r;
    address_high_nxt   = address_high_r;
    record_address_nxt = record_address_r;
    end_record_nxt     = end_record_r;
    output_address_nxt = output_address_r;
    res_valid          = 1'b0;
    res_kind           = RK_DATA;
    res_byte           = '0;
    res_fill           = '0;
    res_err            = '0;

    if (in_accept && !halted) begin
      if (in_chan.kind != KIND_CHAR) begin
        phase_nxt = PH_ERROR;
        res_valid = 1'b1;
        res_kind  = RK_ERROR;
        res_err   = ERR_EARLY;
      end else if (phase_r == PH_HUNT) begin
        if (in_chan.char_code == CHAR_COLON) begin
          running_sum_nxt   = '0;
          second_nibble_nxt = 1'b0;
          phase_nxt         = PH_COUNT;
        end
      end else if (!nib_ok) begin
        phase_nxt = PH_ERROR;
        res_valid = 1'b1;
        res_kind  = RK_ERROR;
        res_err   = ERR_DIGIT;
      end else if (!second_nibble_r) begin
        high_nibble_nxt   = nib_val;
        second_nibble_nxt = 1'b1;
      end else begin
        second_nibble_nxt = 1'b0;
        running_sum_nxt   = sum_new;
        case (phase_r)
          PH_COUNT: begin
            record_length_nxt = byte_val;
            phase_nxt         = PH_AHI;
          end
          PH_AHI: begin
            address_high_nxt = byte_val;
            phase_nxt        = PH_ALO;
          end
          PH_ALO: begin
            record_address_nxt = {address_high_r, byte_val};
            phase_nxt          = PH_TYPE;
          end
          PH_TYPE: begin
            if (byte_val == REC_EOF) begin
              end_record_nxt = 1'b1;
              phase_nxt      = PH_CHECK;
            end else if (byte_val != REC_DATA) begin
              phase_nxt = PH_ERROR;
              res_valid = 1'b1;
              res_kind  = RK_ERROR;
              res_err   = ERR_TYPE;
            end else begin
              end_record_nxt = 1'b0;
              bytes_left_nxt = record_length_r;
              phase_nxt      = (record_length_r != '0) ? PH_DATA : PH_CHECK;
              // The first record sets the base; later ones may leave a gap.
              if (output_address_r == '0) begin
                output_address_nxt = rec_addr_ext;
              end else if (output_address_r > rec_addr_ext) begin
                phase_nxt = PH_ERROR;
                res_valid = 1'b1;
                res_kind  = RK_ERROR;
                res_err   = ERR_SEQ;
              end else if (output_address_r < rec_addr_ext) begin
                output_address_nxt = rec_addr_ext;
                res_valid          = 1'b1;
                res_kind           = RK_FILL;
                res_fill           = record_address_r - output_address_r[FillW-1:0];
              end
            end
          end
          PH_DATA: begin
            bytes_left_nxt = left_dec;
            if (left_dec == '0) begin
              phase_nxt = PH_CHECK;
            end
            res_valid = 1'b1;
            res_kind  = RK_DATA;
            res_byte  = byte_val;
          end
          PH_CHECK: begin
            if (sum_new != '0) begin
              phase_nxt = PH_ERROR;
              res_valid = 1'b1;
              res_kind  = RK_ERROR;
              res_err   = ERR_SUM;
            end else begin
              output_address_nxt = output_address_r + OutAddrW'(record_length_r);
              if (end_record_r) begin
                phase_nxt = PH_DONE;
                res_valid = 1'b1;
                res_kind  = RK_DONE;
              end else begin
                phase_nxt = PH_HUNT;
              end
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  // Output register: load a new result, or hold one that is still waiting.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_fill_nxt  = out_fill_r;
    out_err_nxt   = out_err_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = res_kind;
      out_byte_nxt  = res_byte;
      out_fill_nxt  = res_fill;
      out_err_nxt   = res_err;
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_HUNT;
      second_nibble_r  <= 1'b0;
      high_nibble_r    <= '0;
      running_sum_r    <= '0;
      record_length_r  <= '0;
      bytes_left_r     <= '0;
      address_high_r   <= '0;
      record_address_r <= '0;
      end_record_r     <= 1'b0;
      output_address_r <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      phase_r          <= phase_nxt;
      second_nibble_r  <= second_nibble_nxt;
      high_nibble_r    <= high_nibble_nxt;
      running_sum_r    <= running_sum_nxt;
      record_length_r  <= record_length_nxt;
      bytes_left_r     <= bytes_left_nxt;
      address_high_r   <= address_high_nxt;
      record_address_r <= record_address_nxt;
      end_record_r     <= end_record_nxt;
      output_address_r <= output_address_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_fill_r <= out_fill_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_kind = out_kind_r;
  assign out_chan.data_byte   = out_byte_r;
  assign out_chan.fill_length = out_fill_r;
  assign out_chan.error_code  = out_err_r;

  // Once halted, the decoder stays halted until reset.
  `CHECK_NEXT(a_halt_sticky, clk, rst_n, halted, halted, "halted decoder resumed")

  // A halted decoder never loads a new result.
  `CHECK_SAME(a_halt_silent, clk, rst_n, halted, !res_valid, "result while halted")

  // A waiting error word means the decoder has stopped in the error phase.
  `CHECK_SAME(a_err_phase, clk, rst_n, out_valid_r && (out_kind_r == RK_ERROR),
              phase_r == PH_ERROR, "error word without error phase")

  // A waiting done word means the decoder has stopped in the done phase.
  `CHECK_SAME(a_done_phase, clk, rst_n, out_valid_r && (out_kind_r == RK_DONE),
              phase_r == PH_DONE, "done word without done phase")

  // Half a byte is never pending while hunting for a colon.
  `CHECK_SAME(a_nibble_hunt, clk, rst_n, second_nibble_r, phase_r != PH_HUNT,
              "pending nibble while hunting")

endmodule

>>> tb/sv/intel_hex_record_parser_test.sv
module intel_hex_record_parser_test;
  import ihex_pkg::*;

  // Input word kind that marks the end of the text stream.
  localparam logic KindEnd = 1'b1;

  // Ways the character stream is brought to its end.
  typedef enum int {
    END_DONE,
    END_BAD_DIGIT,
    END_EARLY_RECORD,
    END_EARLY_HUNT,
    END_SEQ,
    END_TYPE,
    END_SUM
  } stream_end_t;

  typedef struct packed {
    logic             kind;
    logic [CharW-1:0] code;
  } char_word_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [7:0]       data;
    logic [FillW-1:0] fill;
    logic [ErrW-1:0]  err;
  } image_word_t;

  logic clk;
  logic rst_n;

  ihex_in_if  char_bus ();
  ihex_out_if image_bus ();

  intel_hex_record_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (char_bus.sink),
    .out_chan (image_bus.source)
  );

  // Text waiting to be sent and image words still owed by the block.
  char_word_t  text_queue[$];
  image_word_t owed_words[$];
  bit          failed = 1'b0;

  // Record builder scratch and the address the next legal record may start at.
  logic [7:0] line_chars[$];
  logic [7:0] line_sum;
  int         layout_end;

  // Decoder state mirrored by the predictor.
  phase_t            hex_phase    = PH_HUNT;
  bit                low_digit    = 1'b0;
  logic [3:0]        upper_digit  = '0;
  logic [7:0]        byte_sum     = '0;
  logic [7:0]        rec_len      = '0;
  logic [7:0]        data_left    = '0;
  logic [7:0]        addr_hi      = '0;
  logic [15:0]       rec_addr     = '0;
  bit                is_eof       = 1'b0;
  logic [OutAddrW-1:0] image_addr = '0;

  // Handshake pacing.
  bit         word_taken = 1'b0;
  int         send_pause = 0;
  int         send_calm  = 0;
  int         take_pause = 0;
  int         take_calm  = 0;
  char_word_t next_word;

  always #1 clk = ~clk;

  // Digit value of an uppercase hex character, or -1.
  function automatic int hex_value(input logic [7:0] c);
    if (c >= CHAR_0 && c <= CHAR_9) return int'(c - CHAR_0);
    if (c >= CHAR_A && c <= CHAR_F) return int'(c - CHAR_A) + int'(NIB_TEN);
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < NIB_TEN) return CHAR_0 + 8'(n);
    return CHAR_A + 8'(n - NIB_TEN);
  endfunction

  // Mostly no pause, some short ones, a few long ones, and calm stretches.
  function automatic int pick_pause(inout int calm_left);
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  task automatic owe(input logic [KindW-1:0] kind, input logic [7:0] data,
                     input logic [FillW-1:0] fill, input logic [ErrW-1:0] err);
    owed_words.push_back('{kind: kind, data: data, fill: fill, err: err});
  endtask

  task automatic halt_with(input logic [ErrW-1:0] err);
    hex_phase = PH_ERROR;
    owe(RK_ERROR, 8'h00, '0, err);
  endtask

  // Applies one accepted character word to the mirrored decoder.
  task automatic take_word(input logic kind, input logic [7:0] ch);
    int                  digit;
    logic [7:0]          b;
    logic [OutAddrW-1:0] gap;
    if (hex_phase == PH_DONE || hex_phase == PH_ERROR) return;
    if (kind != KIND_CHAR) begin
      halt_with(ERR_EARLY);
      return;
    end
    if (hex_phase == PH_HUNT) begin
      if (ch == CHAR_COLON) begin
        byte_sum  = '0;
        low_digit = 1'b0;
        hex_phase = PH_COUNT;
      end
      return;
    end
    digit = hex_value(ch);
    if (digit < 0) begin
      halt_with(ERR_DIGIT);
      return;
    end
    if (!low_digit) begin
      upper_digit = 4'(digit);
      low_digit   = 1'b1;
      return;
    end
    low_digit = 1'b0;
    b         = {upper_digit, 4'(digit)};
    byte_sum  = byte_sum + b;

    // One full byte of the record has been decoded.
    case (hex_phase)
      PH_COUNT: begin
        rec_len   = b;
        hex_phase = PH_AHI;
      end
      PH_AHI: begin
        addr_hi   = b;
        hex_phase = PH_ALO;
      end
      PH_ALO: begin
        rec_addr  = {addr_hi, b};
        hex_phase = PH_TYPE;
      end
      PH_TYPE: begin
        if (b == REC_EOF) begin
          is_eof    = 1'b1;
          hex_phase = PH_CHECK;
        end else if (b != REC_DATA) begin
          halt_with(ERR_TYPE);
        end else begin
          is_eof    = 1'b0;
          data_left = rec_len;
          hex_phase = (rec_len != 0) ? PH_DATA : PH_CHECK;
          if (image_addr == 0) begin
            // The first record only sets the base address.
            image_addr = {1'b0, rec_addr};
          end else if (image_addr > {1'b0, rec_addr}) begin
            halt_with(ERR_SEQ);
          end else if (image_addr < {1'b0, rec_addr}) begin
            gap        = {1'b0, rec_addr} - image_addr;
            image_addr = {1'b0, rec_addr};
            owe(RK_FILL, 8'h00, gap[FillW-1:0], '0);
          end
        end
      end
      PH_DATA: begin
        data_left = data_left - 8'd1;
        if (data_left == 0) hex_phase = PH_CHECK;
        owe(RK_DATA, b, '0, '0);
      end
      PH_CHECK: begin
        if (byte_sum != 0) begin
          halt_with(ERR_SUM);
        end else begin
          image_addr = image_addr + OutAddrW'(rec_len);
          if (is_eof) begin
            hex_phase = PH_DONE;
            owe(RK_DONE, 8'h00, '0, '0);
          end else begin
            hex_phase = PH_HUNT;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Compares the image word on the bus with the oldest one owed.
  task automatic check_word();
    image_word_t got;
    image_word_t want;
    got = '{kind: image_bus.result_kind, data: image_bus.data_byte,
            fill: image_bus.fill_length, err: image_bus.error_code};
    if (owed_words.size() == 0) begin
      $display("%0t: unexpected word kind %0d data %02h fill %0d err %0d",
               $time, got.kind, got.data, got.fill, got.err);
      failed = 1'b1;
    end else begin
      want = owed_words.pop_front();
      if (got.kind !== want.kind || got.data !== want.data ||
          got.fill !== want.fill || got.err !== want.err) begin
        $display("%0t: expected kind %0d data %02h fill %0d err %0d,",
                 $time, want.kind, want.data, want.fill, want.err,
                 " got kind %0d data %02h fill %0d err %0d",
                 got.kind, got.data, got.fill, got.err);
        failed = 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------

  task automatic put_word(input logic kind, input logic [7:0] c);
    text_queue.push_back('{kind: kind, code: c});
  endtask

  task automatic add_byte(input logic [7:0] b);
    line_chars.push_back(hex_char(b[7:4]));
    line_chars.push_back(hex_char(b[3:0]));
    line_sum = line_sum + b;
  endtask

  // Builds one record; sum_skew spoils the checksum when nonzero.
  task automatic build_line(input logic [7:0] len, input logic [15:0] addr,
                            input logic [7:0] rtype, input bit extreme_data,
                            input logic [7:0] sum_skew);
    logic [7:0] val;
    line_chars.delete();
    line_sum = 8'h00;
    line_chars.push_back(CHAR_COLON);
    add_byte(len);
    add_byte(addr[15:8]);
    add_byte(addr[7:0]);
    add_byte(rtype);
    if (rtype == REC_DATA) begin
      for (int i = 0; i < len; i++) begin
        if (extreme_data) val = (i % 2 == 1) ? 8'hFF : 8'h00;
        else val = 8'($urandom_range(0, 255));
        add_byte(val);
      end
    end
    val = 8'h00 - line_sum + sum_skew;
    add_byte(val);
  endtask

  task automatic commit_line();
    foreach (line_chars[i]) put_word(KIND_CHAR, line_chars[i]);
  endtask

  // Line breaks and stray characters between records; never a colon.
  task automatic add_noise();
    int         n;
    logic [7:0] c;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        put_word(KIND_CHAR, 8'h0D);
        put_word(KIND_CHAR, 8'h0A);
      end else begin
        do c = 8'($urandom_range(0, 255)); while (c == CHAR_COLON);
        put_word(KIND_CHAR, c);
      end
    end
  endtask

  task automatic add_data_record(input int len, input int gap, input bit extreme_data);
    logic [15:0] addr;
    addr = 16'(layout_end + gap);
    build_line(8'(len), addr, REC_DATA, extreme_data, 8'h00);
    layout_end = addr + len;
    commit_line();
  endtask

  function automatic logic [7:0] bad_digit_char();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) return 8'h61 + 8'($urandom_range(0, 5));
    do c = 8'($urandom_range(0, 255)); while (hex_value(c) >= 0);
    return c;
  endfunction

  // A legal data record that is then cut short or spoiled at some character.
  task automatic spoiled_record(input bit cut_short);
    int pos;
    build_line(8'($urandom_range(1, 8)), 16'(layout_end + $urandom_range(0, 16)),
               REC_DATA, 1'b0, 8'h00);
    pos = $urandom_range(1, line_chars.size() - 1);
    if (cut_short) begin
      while (line_chars.size() > pos) void'(line_chars.pop_back());
      commit_line();
      put_word(KindEnd, 8'($urandom_range(0, 255)));
    end else begin
      line_chars[pos] = bad_digit_char();
      commit_line();
    end
  endtask

  // Closes the stream with the end record or one of the error cases.
  task automatic finish_stream();
    stream_end_t how;
    how = stream_end_t'($urandom_range(0, 6));
    case (how)
      END_DONE:
        build_line(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                   REC_EOF, 1'b0, 8'h00);
      END_SEQ:
        build_line(8'($urandom_range(0, 8)), 16'($urandom_range(0, layout_end - 1)),
                   REC_DATA, 1'b0, 8'h00);
      END_TYPE:
        build_line(8'($urandom_range(0, 8)), 16'(layout_end + $urandom_range(0, 16)),
                   8'($urandom_range(2, 255)), 1'b0, 8'h00);
      END_SUM:
        build_line(8'($urandom_range(0, 8)), 16'(layout_end + $urandom_range(0, 16)),
                   REC_DATA, 1'b0, 8'($urandom_range(1, 255)));
      default: ;
    endcase
    case (how)
      END_BAD_DIGIT:    spoiled_record(1'b0);
      END_EARLY_RECORD: spoiled_record(1'b1);
      END_EARLY_HUNT:   put_word(KindEnd, 8'($urandom_range(0, 255)));
      default:          commit_line();
    endcase
    // The block is halted from here on; these words must cause nothing.
    for (int i = 0; i < 20; i++) begin
      put_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_stream();
    int len;
    int gap;
    int roll;
    // Stray characters while hunting, then short records with extreme data,
    // an empty record, a record with no gap and one with a one-byte gap.
    put_word(KIND_CHAR, 8'h00);
    put_word(KIND_CHAR, 8'hFF);
    put_word(KIND_CHAR, 8'h61);
    layout_end = $urandom_range(0, 64);
    add_data_record(2, 0, 1'b1);
    add_noise();
    add_data_record(0, 0, 1'b0);
    add_data_record(3, 0, 1'b0);
    add_data_record(1, 1, 1'b1);
    add_noise();

    // Random well-formed records with random content and gaps.
    while (text_queue.size() < 380) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) len = $urandom_range(0, 8);
      else len = $urandom_range(9, 40);
      roll = $urandom_range(0, 99);
      if (roll < 50) gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 16);
      else gap = $urandom_range(17, 1024);
      add_data_record(len, gap, 1'b0);
      add_noise();
    end

    // Sometimes a long zero fill up near the top of the address space.
    if ($urandom_range(0, 3) == 0) begin
      len = $urandom_range(0, 8);
      add_data_record(len, $urandom_range(16'hF000, 16'hFFE0) - layout_end, 1'b0);
      add_noise();
    end
    finish_stream();
  endtask

  // ---------------------------------------------------------------------
  // Driver: changes inputs at the falling edge.
  // ---------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst_n) begin
      char_bus.valid  <= 1'b0;
      image_bus.ready <= 1'b0;
    end else begin
      // Present the next character word once the current one is gone.
      if (!char_bus.valid || word_taken) begin
        word_taken = 1'b0;
        if (send_pause > 0) begin
          send_pause--;
          char_bus.valid <= 1'b0;
        end else if (text_queue.size() > 0) begin
          next_word = text_queue.pop_front();
          char_bus.valid     <= 1'b1;
          char_bus.kind      <= next_word.kind;
          char_bus.char_code <= next_word.code;
          send_pause = pick_pause(send_calm);
        end else begin
          char_bus.valid <= 1'b0;
        end
      end

      // Stall the image side now and then.
      if (take_pause > 0) begin
        take_pause--;
        image_bus.ready <= 1'b0;
      end else begin
        image_bus.ready <= 1'b1;
        take_pause = pick_pause(take_calm);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge.
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n) begin
      if (image_bus.valid && image_bus.ready) check_word();
      if (char_bus.valid && char_bus.ready) begin
        take_word(char_bus.kind, char_bus.char_code);
        word_taken = 1'b1;
      end
    end
  end

  // Run control.
  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    char_bus.valid     = 1'b0;
    char_bus.kind      = KIND_CHAR;
    char_bus.char_code = '0;
    image_bus.ready    = 1'b0;
    build_stream();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (text_queue.size() > 0 || char_bus.valid) @(posedge clk);
    while (owed_words.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (!failed && owed_words.size() == 0) begin
      $display("intel_hex_record_parser regression: pass");
    end else begin
      $display("intel_hex_record_parser regression: fail");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("intel_hex_record_parser regression: fail");
    $finish;
  end

endmodule

>>> intel_hex_record_parser.f
+incdir+hw/rtl
hw/rtl/ihex_pkg.sv
hw/rtl/ihex_in_if.sv
hw/rtl/ihex_out_if.sv
hw/rtl/intel_hex_record_parser.sv
tb/sv/intel_hex_record_parser_test.sv
